### hw/rtl/sbi_pkg.sv
// Shared constants for the segment versus box crossing block.
// No dependencies; used by segment_box_intersect_top.
`default_nettype none

package sbi_pkg;

    // Box edges tested per request: top, right, bottom, left
    localparam int unsigned NUM_EDGES = 4;

    // Result stream: hit in bit 0, zero filled to one byte
    localparam int unsigned OUT_TDATA_W = 8;

    // Pipeline depth: corners, offsets, products, numerators, edge tests, output
    localparam int unsigned NUM_STAGES = 6;

endpackage : sbi_pkg

`default_nettype wire

### hw/rtl/segment_box_intersect_top.sv
// Segment versus axis-aligned box crossing test, fully pipelined.
// Depends on sbi_pkg for stage count, edge count and result width.
`default_nettype none

// One request (segment end points, box center and half extents, signed
// Q12.4) is taken each clock cycle unless a stall fills all stages, giving
// one result: hit is 1 when the segment crosses or touches any of the four box
// edges, parallel and zero-length edges never count. The six register stages
// are corner build, corner-to-start offsets, ten parallel signed multipliers
// of (COORD_WIDTH+2) bits, numerator/denominator sums, per-edge range compares
// and the output register; the multiplier stage sets the clock limit. Each
// stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so bubbles close up under back-pressure and a stalled result
// does not hold up requests behind it while there is a free stage.
module segment_box_intersect_top #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  wire  aclk,
    input  wire  aresetn,
    // request channel
    input  wire  s_tvalid,
    output logic s_tready,
    // s_tdata, low bit up: seg_start_x, seg_start_y, seg_end_x, seg_end_y,
    // box_center_x, box_center_y (COORD_WIDTH each), box_half_w,
    // box_half_h (COORD_WIDTH-1 each), zero fill to whole bytes
    input  wire  [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
    // result channel
    output logic m_tvalid,
    input  wire  m_tready,
    // m_tdata, low bit up: hit, zero fill
    output logic [sbi_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned CW  = W + 1;       // corners, segment direction
    localparam int unsigned QW  = W + 2;       // offsets, multiplier operands
    localparam int unsigned PW  = 2 * QW;      // products and numerators
    localparam int unsigned NS  = sbi_pkg::NUM_STAGES;
    localparam int unsigned NE  = sbi_pkg::NUM_EDGES;
    localparam int unsigned HW_OFS = 6 * W;
    localparam int unsigned HH_OFS = 7 * W - 1;

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or drains this cycle
    // ------------------------------------------------------------------
    logic [NS-1:0] vld_reg, vld_next;
    logic [NS-1:0] rdy;

    always_comb begin
        rdy[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next = vld_reg;
        if (rdy[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[NS-1];

    // ------------------------------------------------------------------
    // Stage 0: unpack, box corners, segment direction, doubled extents
    // ------------------------------------------------------------------
    logic signed [W-1:0]  in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic        [W-2:0]  in_hw, in_hh;
    logic signed [CW-1:0] lx_next, rxe_next, ty_next, by_next;
    logic signed [CW-1:0] rx_next, ry_next, sx_next, sy_next;

    always_comb begin
        in_ax = signed'(s_tdata[0*W +: W]);
        in_ay = signed'(s_tdata[1*W +: W]);
        in_bx = signed'(s_tdata[2*W +: W]);
        in_by = signed'(s_tdata[3*W +: W]);
        in_cx = signed'(s_tdata[4*W +: W]);
        in_cy = signed'(s_tdata[5*W +: W]);
        in_hw = s_tdata[HW_OFS +: W-1];
        in_hh = s_tdata[HH_OFS +: W-1];

        lx_next  = CW'(in_cx) - signed'({2'b00, in_hw});
        rxe_next = CW'(in_cx) + signed'({2'b00, in_hw});
        ty_next  = CW'(in_cy) - signed'({2'b00, in_hh});
        by_next  = CW'(in_cy) + signed'({2'b00, in_hh});
        rx_next  = CW'(in_bx) - CW'(in_ax);
        ry_next  = CW'(in_by) - CW'(in_ay);
        sx_next  = signed'({1'b0, in_hw, 1'b0});
        sy_next  = signed'({1'b0, in_hh, 1'b0});
    end

    logic signed [W-1:0]  s0_ax_reg, s0_ay_reg;
    logic signed [CW-1:0] s0_lx_reg, s0_rxe_reg, s0_ty_reg, s0_by_reg;
    logic signed [CW-1:0] s0_rx_reg, s0_ry_reg, s0_sx_reg, s0_sy_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s0_ax_reg  <= in_ax;
            s0_ay_reg  <= in_ay;
            s0_lx_reg  <= lx_next;
            s0_rxe_reg <= rxe_next;
            s0_ty_reg  <= ty_next;
            s0_by_reg  <= by_next;
            s0_rx_reg  <= rx_next;
            s0_ry_reg  <= ry_next;
            s0_sx_reg  <= sx_next;
            s0_sy_reg  <= sy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: corner offsets from the segment start, widen operands
    // ------------------------------------------------------------------
    logic signed [QW-1:0] s1_qlx_reg, s1_qrx_reg, s1_qty_reg, s1_qby_reg;
    logic signed [QW-1:0] s1_rx_reg, s1_ry_reg, s1_sx_reg, s1_sy_reg;

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s1_qlx_reg <= QW'(s0_lx_reg)  - QW'(s0_ax_reg);
            s1_qrx_reg <= QW'(s0_rxe_reg) - QW'(s0_ax_reg);
            s1_qty_reg <= QW'(s0_ty_reg)  - QW'(s0_ay_reg);
            s1_qby_reg <= QW'(s0_by_reg)  - QW'(s0_ay_reg);
            s1_rx_reg  <= QW'(s0_rx_reg);
            s1_ry_reg  <= QW'(s0_ry_reg);
            s1_sx_reg  <= QW'(s0_sx_reg);
            s1_sy_reg  <= QW'(s0_sy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: products. Horizontal edges have s=(sx,0), vertical (0,sy).
    // Left and top edges share their start corner, so nu of the top edge
    // equals nu of the left edge.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s2_dh_reg, s2_dv_reg;          // ry*sx, rx*sy
    logic signed [PW-1:0] s2_pt_reg, s2_pb_reg;          // qty*sx, qby*sx
    logic signed [PW-1:0] s2_pr_reg, s2_pl_reg;          // qrx*sy, qlx*sy
    logic signed [PW-1:0] s2_lry_reg, s2_rry_reg;        // qlx*ry, qrx*ry
    logic signed [PW-1:0] s2_trx_reg, s2_brx_reg;        // qty*rx, qby*rx

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s2_dh_reg  <= s1_ry_reg  * s1_sx_reg;
            s2_dv_reg  <= s1_rx_reg  * s1_sy_reg;
            s2_pt_reg  <= s1_qty_reg * s1_sx_reg;
            s2_pb_reg  <= s1_qby_reg * s1_sx_reg;
            s2_pr_reg  <= s1_qrx_reg * s1_sy_reg;
            s2_pl_reg  <= s1_qlx_reg * s1_sy_reg;
            s2_lry_reg <= s1_qlx_reg * s1_ry_reg;
            s2_rry_reg <= s1_qrx_reg * s1_ry_reg;
            s2_trx_reg <= s1_qty_reg * s1_rx_reg;
            s2_brx_reg <= s1_qby_reg * s1_rx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: denominators and numerators per edge
    // horizontal: den=-ry*sx, nt=-qy*sx; vertical: den=rx*sy, nt=qx*sy
    // nu = qx*ry - qy*rx
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s3_denh_reg, s3_denv_reg;
    logic signed [PW-1:0] s3_ntt_reg, s3_ntr_reg, s3_ntb_reg, s3_ntl_reg;
    logic signed [PW-1:0] s3_nutl_reg, s3_nur_reg, s3_nub_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            s3_denh_reg <= -s2_dh_reg;
            s3_denv_reg <= s2_dv_reg;
            s3_ntt_reg  <= -s2_pt_reg;
            s3_ntb_reg  <= -s2_pb_reg;
            s3_ntr_reg  <= s2_pr_reg;
            s3_ntl_reg  <= s2_pl_reg;
            s3_nutl_reg <= s2_lry_reg - s2_trx_reg;
            s3_nur_reg  <= s2_rry_reg - s2_trx_reg;
            s3_nub_reg  <= s2_lry_reg - s2_brx_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: per-edge test, 0<=t<=1 and 0<=u<=1 without division
    // ------------------------------------------------------------------
    function automatic logic edge_ok(input logic signed [PW-1:0] den,
                                     input logic signed [PW-1:0] nt,
                                     input logic signed [PW-1:0] nu);
        logic ok;
        if (den == '0) begin
            ok = 1'b0;                  // parallel or degenerate edge
        end else if (!den[PW-1]) begin
            ok = !nt[PW-1] && (nt <= den) && !nu[PW-1] && (nu <= den);
        end else begin
            ok = (nt[PW-1] || (nt == '0)) && (nt >= den) &&
                 (nu[PW-1] || (nu == '0)) && (nu >= den);
        end
        return ok;
    endfunction

    logic [NE-1:0] s4_ehit_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            s4_ehit_reg[0] <= edge_ok(s3_denh_reg, s3_ntt_reg, s3_nutl_reg);
            s4_ehit_reg[1] <= edge_ok(s3_denv_reg, s3_ntr_reg, s3_nur_reg);
            s4_ehit_reg[2] <= edge_ok(s3_denh_reg, s3_ntb_reg, s3_nub_reg);
            s4_ehit_reg[3] <= edge_ok(s3_denv_reg, s3_ntl_reg, s3_nutl_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: output register
    // ------------------------------------------------------------------
    logic s5_hit_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            s5_hit_reg <= |s4_ehit_reg;
        end
    end

    assign m_tdata = {{(sbi_pkg::OUT_TDATA_W-1){1'b0}}, s5_hit_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic in_acc, out_acc;
    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // occupancy changes only by accepted and delivered requests
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(vld_reg) + int'($past(out_acc)) ==
             $countones($past(vld_reg)) + int'($past(in_acc))))
        else $error("pipeline occupancy mismatch");

    // input is held off only when every stage is full
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&vld_reg))
        else $error("input stalled with a free stage");

    // a full pipeline with a stalled output must refuse new requests
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_tready) |-> !s_tready)
        else $error("request taken into a full, stalled pipeline");

endmodule : segment_box_intersect_top

`default_nettype wire
